// ----- rtl/urc_pkg.sv -----
// Package for the ultrasonic range controller: widths, codes, phase type,
// divider request/response structs and the phase encoder.
// No dependencies; used by urc_div and ultrasonic_range_controller_core.
`default_nettype none

package urc_pkg;

    // Moving-average window
    localparam int WINDOW_DEPTH = 5;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    // Distance arithmetic: sample = (w*160 + 29) / 58 in 1/16 mm
    localparam int WIDTH_W = 16;
    localparam int NUM_W = 24;
    localparam int SAMPLE_W = 18;
    localparam int SAMPLE_MAX = 180786;
    localparam int SAMPLE_DIVISOR = 58;
    localparam int SAMPLE_ROUND = 29;
    localparam int SUM_W = $clog2(WINDOW_DEPTH * SAMPLE_MAX + 1);
    localparam int MEAN_W = 19;

    // Shared serial divider
    localparam int DIV_W = (NUM_W > SUM_W + 2) ? NUM_W : SUM_W + 2;
    localparam int DVS_A = $clog2(SAMPLE_DIVISOR + 1);
    localparam int DVS_B = FILL_W + 1;
    localparam int DVS_W = (DVS_A > DVS_B) ? DVS_A : DVS_B;
    localparam int CNT_W = $clog2(DIV_W);

    // Stream and configuration widths
    localparam int TIME_W = 32;
    localparam int CFG_MS_W = 16;
    localparam int PERIOD_W = 17;
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PERIOD = 2'd2;

    localparam logic [CFG_MS_W-1:0] TIMEOUT_RESET = 16'd100;
    localparam logic [CFG_MS_W-1:0] COOLDOWN_RESET = 16'd65;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd20000;
    localparam logic signed [MEAN_W-1:0] MEAN_RESET = -19'sd16;

    // Request operation codes
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_EDGE = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Reported measurement state codes
    localparam logic [1:0] MS_IDLE = 2'd0;
    localparam logic [1:0] MS_TRIG = 2'd1;
    localparam logic [1:0] MS_COOL = 2'd2;

    // Sensor phase
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_TRIG = 3'b010,
        PH_COOL = 3'b100
    } t_phase;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        case (ph)
            PH_IDLE: code = MS_IDLE;
            PH_TRIG: code = MS_TRIG;
            PH_COOL: code = MS_COOL;
            default: code = MS_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ultrasonic_range_controller_core.sv -----
// Ultrasonic range controller: trigger/echo sequencing, pulse width to
// distance and moving average. Depends on urc_pkg and urc_div.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready | tuser: operation; tdata: now_ms,
//          |     |                     |   echo_level, timer_count
//  m       | out | o_m_tvalid/i_m_tready | tdata: trigger_request, average_distance,
//          |     |                     |   new_data, measure_state
//  cfg     | in  | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// Most requests take the fast path: the result is loaded into the output register
// at the edge the request is accepted.
// An update that turns a captured echo into a sample goes through these steps
// from acceptance to result load: the sample pass of the bit-serial divider,
// the window update, the start of the mean, the mean pass of the divider, the
// capture of the mean and the load of the result once the output is free.
// One request is in flight at a time.
// Reset (synchronous, active low) restores the register defaults, idle phase
// and a mean of -1 mm. A stalled output holds its result; the input is ready
// again once the output register is free or being taken.
`default_nettype none

module ultrasonic_range_controller_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata: [31:0] now_ms, [32] echo_level, [48:33] timer_count, [55:49] zero
    input  wire logic [urc_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // tuser: [1:0] operation
    input  wire logic [1:0]                       i_s_tuser,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // tdata: [0] trigger_request, [19:1] average_distance, [20] new_data,
    //        [22:21] measure_state, [23] zero
    output logic [urc_pkg::OUT_DATA_W-1:0]        o_m_tdata,
    input  wire logic                             i_cfg_we,
    input  wire logic [urc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [urc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import urc_pkg::*;

    typedef enum logic [4:0] {
        S_READY = 5'b00001,
        S_SAMP  = 5'b00010,
        S_SUM   = 5'b00100,
        S_MEAN  = 5'b01000,
        S_HOLD  = 5'b10000
    } t_ctl_state;

    // Configuration
    logic [CFG_MS_W-1:0]       r_timeout;
    logic [CFG_MS_W-1:0]       r_cooldown;
    logic [PERIOD_W-1:0]       r_period;

    // Controller and sensor state
    t_ctl_state                r_st, n_st;
    t_phase                    r_phase, n_phase;
    logic [TIME_W-1:0]         r_trig_time, n_trig_time;
    logic [WIDTH_W-1:0]        r_start_cnt, n_start_cnt;
    logic [WIDTH_W-1:0]        r_width, n_width;
    logic                      r_captured, n_captured;
    logic                      r_fresh, n_fresh;
    logic [POS_W-1:0]          r_pos;
    logic [FILL_W-1:0]         r_fill;
    logic [SUM_W-1:0]          r_sum;
    logic signed [MEAN_W-1:0]  r_mean;
    logic [SAMPLE_W-1:0]       r_window [WINDOW_DEPTH];

    // Output register
    logic                      r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data, n_out_data;

    // Request fields
    logic                      s_accept;
    logic [1:0]                in_op;
    logic [TIME_W-1:0]         in_now;
    logic                      in_level;
    logic [WIDTH_W-1:0]        in_count;

    logic [TIME_W-1:0]         elapsed;
    logic signed [PERIOD_W+1:0] wrap_width;
    logic [WIDTH_W-1:0]        edge_width;
    logic                      trig_req;
    logic                      flag_out;
    logic [NUM_W-1:0]          sample_num;
    logic [SAMPLE_W-1:0]       new_sample;
    logic [SUM_W-1:0]          drop_val;
    logic                      out_free;

    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    assign in_op = i_s_tuser;
    assign in_now = i_s_tdata[31:0];
    assign in_level = i_s_tdata[32];
    assign in_count = i_s_tdata[48:33];

    assign out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_st == S_READY) && out_free;
    assign s_accept = i_s_tvalid && o_s_tready;

    assign elapsed = in_now - r_trig_time;

    // Falling-edge width with timer wrap correction, clamped to 16 bits
    assign wrap_width = $signed({3'b000, in_count}) - $signed({3'b000, r_start_cnt})
                        + $signed({2'b00, r_period});
    always_comb begin
        if (in_count >= r_start_cnt) begin
            edge_width = in_count - r_start_cnt;
        end else if (wrap_width < 0) begin
            edge_width = '0;
        end else if (wrap_width > $signed((PERIOD_W+2)'(2**WIDTH_W - 1))) begin
            edge_width = '1;
        end else begin
            edge_width = wrap_width[WIDTH_W-1:0];
        end
    end

    // w*160 + 29 as shifts and adds
    assign sample_num = (NUM_W'(r_width) << 7) + (NUM_W'(r_width) << 5)
                        + NUM_W'(SAMPLE_ROUND);
    assign new_sample = div_rsp.quotient[SAMPLE_W-1:0];
    assign drop_val = (r_fill == FILL_W'(WINDOW_DEPTH)) ? SUM_W'(r_window[r_pos]) : '0;

    // Request decode and sequencing
    always_comb begin
        n_st = r_st;
        n_phase = r_phase;
        n_trig_time = r_trig_time;
        n_start_cnt = r_start_cnt;
        n_width = r_width;
        n_captured = r_captured;
        n_fresh = r_fresh;
        n_out_valid = r_out_valid;
        n_out_data = r_out_data;
        trig_req = 1'b0;
        flag_out = 1'b0;
        div_req.start = 1'b0;
        div_req.dividend = DIV_W'(sample_num);
        div_req.divisor = DVS_W'(SAMPLE_DIVISOR);

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_st)
            S_READY: begin
                if (s_accept) begin
                    case (in_op)
                        OP_UPDATE: begin
                            case (r_phase)
                                PH_IDLE: begin
                                    n_captured = 1'b0;
                                    trig_req = 1'b1;
                                    n_trig_time = in_now;
                                    n_phase = PH_TRIG;
                                end
                                PH_TRIG: begin
                                    if (r_captured) begin
                                        n_phase = PH_COOL;
                                        n_fresh = 1'b1;
                                        n_st = S_SAMP;
                                        div_req.start = 1'b1;
                                    end else if (elapsed >= TIME_W'(r_timeout)) begin
                                        n_phase = PH_COOL;
                                    end
                                end
                                PH_COOL: begin
                                    if (elapsed >= TIME_W'(r_cooldown)) begin
                                        n_phase = PH_IDLE;
                                    end
                                end
                                default: n_phase = PH_IDLE;
                            endcase
                        end
                        OP_EDGE: begin
                            if (in_level) begin
                                n_start_cnt = in_count;
                            end else begin
                                n_width = edge_width;
                                n_captured = 1'b1;
                            end
                        end
                        OP_QUERY: n_fresh = 1'b0;
                        default: ;
                    endcase
                    flag_out = (in_op == OP_QUERY) ? r_fresh : n_fresh;
                    // Fast path: result goes straight to the output register
                    if (n_st == S_READY) begin
                        n_out_valid = 1'b1;
                        n_out_data = {1'b0, phase_code(n_phase), flag_out,
                                      r_mean, trig_req};
                    end
                end
            end
            S_SAMP: begin
                if (div_rsp.done) begin
                    n_st = S_SUM;
                end
            end
            S_SUM: begin
                div_req.start = 1'b1;
                div_req.dividend = (DIV_W'(r_sum) << 1) + DIV_W'(r_fill);
                div_req.divisor = DVS_W'({r_fill, 1'b0});
                n_st = S_MEAN;
            end
            S_MEAN: begin
                if (div_rsp.done) begin
                    n_st = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data = {1'b0, phase_code(r_phase), r_fresh, r_mean, 1'b0};
                    n_st = S_READY;
                end
            end
            default: n_st = S_READY;
        endcase
    end

    urc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_cooldown <= COOLDOWN_RESET;
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ECHO_TIMEOUT: r_timeout <= i_cfg_data[CFG_MS_W-1:0];
                CFG_COOLDOWN:     r_cooldown <= i_cfg_data[CFG_MS_W-1:0];
                CFG_TIMER_PERIOD: r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_READY;
            r_phase <= PH_IDLE;
            r_trig_time <= '0;
            r_start_cnt <= '0;
            r_width <= '0;
            r_captured <= 1'b0;
            r_fresh <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            r_phase <= n_phase;
            r_trig_time <= n_trig_time;
            r_start_cnt <= n_start_cnt;
            r_width <= n_width;
            r_captured <= n_captured;
            r_fresh <= n_fresh;
            r_out_valid <= n_out_valid;
        end
    end

    // Window bookkeeping and mean
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_fill <= '0;
            r_sum <= '0;
            r_mean <= MEAN_RESET;
        end else begin
            if (r_st == S_SAMP && div_rsp.done) begin
                r_sum <= r_sum - drop_val + SUM_W'(new_sample);
                r_pos <= (r_pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : r_pos + 1'b1;
                if (r_fill != FILL_W'(WINDOW_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (r_st == S_MEAN && div_rsp.done) begin
                r_mean <= $signed(div_rsp.quotient[MEAN_W-1:0]);
            end
        end
    end

    // Sample storage
    always_ff @(posedge i_clk) begin
        if (r_st == S_SAMP && div_rsp.done) begin
            r_window[r_pos] <= new_sample;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = r_out_data;

    // Divider is started only from the ready or sum step
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (r_st == S_READY || r_st == S_SUM))
        else $error("divider started outside ready/sum step");

    // While a sample is in flight the new-data flag is set and phase is cooldown
    a_busy_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_READY) |-> (r_fresh && r_phase == PH_COOL))
        else $error("sample in flight without fresh flag or cooldown phase");

    // Divider works while a division step is pending
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SAMP || r_st == S_MEAN) |-> (div_rsp.busy || div_rsp.done))
        else $error("division step without divider activity");

    // Mean divide completes into the hold step
    a_mean_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_MEAN && div_rsp.done) |=> (r_st == S_HOLD && r_fill != '0))
        else $error("mean result not held or empty window");

endmodule

`default_nettype wire

// ----- rtl/urc_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on urc_pkg (widths, request/response structs).
`default_nettype none

module urc_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire urc_pkg::t_div_req i_req,
    output urc_pkg::t_div_rsp      o_rsp
);
    import urc_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_diff;
    logic             rem_ge;

    // One trial subtraction per cycle
    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};
    assign rem_ge = (rem_sh >= {1'b0, r_dvs});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire
